@@ rtl/tlp_pkg.sv @@
`timescale 1ns / 1ps

package tlp_pkg;

    // Fixed widths of the request and result fields
    localparam int FIELD_BITS = 48;
    localparam int COUNT_BITS = 48;

    // Defaults for the top-level parameters
    localparam int TABLE_ENTRIES_DEFAULT = 1024;
    localparam int HISTORY_BITS_DEFAULT  = 5;
    localparam int ADDRESS_BITS_DEFAULT  = 48;

    // Result classification
    typedef enum logic [1:0] {
        OUTCOME_CORRECT = 2'd0,
        OUTCOME_WRONG   = 2'd1,
        OUTCOME_MISS    = 2'd2
    } outcome_t;

    // One statistics update, issued when a branch retires from the update stage
    typedef struct packed {
        logic     en;
        outcome_t code;
    } count_bump_t;

endpackage

@@ rtl/tlp_branch_if.sv @@
`timescale 1ns / 1ps

interface tlp_branch_if;
    logic                            valid;
    logic                            ready;
    logic [tlp_pkg::FIELD_BITS-1:0]  branch_address;
    logic [tlp_pkg::FIELD_BITS-1:0]  target_address;
    logic                            taken;

    modport source (
        output valid,
        output branch_address,
        output target_address,
        output taken,
        input  ready
    );

    modport sink (
        input  valid,
        input  branch_address,
        input  target_address,
        input  taken,
        output ready
    );
endinterface

@@ rtl/tlp_result_if.sv @@
`timescale 1ns / 1ps

interface tlp_result_if;
    logic                            valid;
    logic                            ready;
    logic [1:0]                      outcome;
    logic                            predicted_taken;
    logic [tlp_pkg::COUNT_BITS-1:0]  correct_count;
    logic [tlp_pkg::COUNT_BITS-1:0]  wrong_count;
    logic [tlp_pkg::COUNT_BITS-1:0]  miss_count;

    modport source (
        output valid,
        output outcome,
        output predicted_taken,
        output correct_count,
        output wrong_count,
        output miss_count,
        input  ready
    );

    modport sink (
        input  valid,
        input  outcome,
        input  predicted_taken,
        input  correct_count,
        input  wrong_count,
        input  miss_count,
        output ready
    );
endinterface

@@ rtl/tlp_slot_mem.sv @@
`timescale 1ns / 1ps

// Per-branch slot memory: history and tag pair per entry.
// One registered read port, one write port, zero sweep after reset.
module tlp_slot_mem #(
    parameter int DEPTH = tlp_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int DW    = 101,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output logic [DW-1:0] rd_data,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  logic [DW-1:0] wr_data,
    output logic          busy
);

    logic [DW-1:0] ram_reg [DEPTH];
    logic [DW-1:0] rd_data_reg;
    logic          clr_active_reg;
    logic          clr_active_next;
    logic [AW-1:0] clr_idx_reg;
    logic [AW-1:0] clr_idx_next;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;

    // Clear sweep control
    always_comb
    begin
        clr_active_next = clr_active_reg;
        clr_idx_next    = clr_idx_reg;
        if (clr_active_reg)
        begin
            clr_idx_next = clr_idx_reg + AW'(1);
            if (clr_idx_reg == AW'(DEPTH - 1))
            begin
                clr_active_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_active_reg <= 1'b1;
            clr_idx_reg    <= '0;
        end
        else
        begin
            clr_active_reg <= clr_active_next;
            clr_idx_reg    <= clr_idx_next;
        end
    end

    // Write port shared between sweep and updates
    assign we    = clr_active_reg || wr_en;
    assign waddr = clr_active_reg ? clr_idx_reg : wr_addr;
    assign wdata = clr_active_reg ? '0 : wr_data;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
    end

    // Registered read; old data on a same-address write
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= ram_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;
    assign busy    = clr_active_reg;

endmodule

@@ rtl/tlp_pattern_table.sv @@
`timescale 1ns / 1ps

// Shared pattern table: one outcome bit per history value, cleared at reset.
module tlp_pattern_table #(
    parameter int HISTORY_BITS = tlp_pkg::HISTORY_BITS_DEFAULT,
    parameter int ENTRIES      = 2 ** HISTORY_BITS
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic [HISTORY_BITS-1:0] rd_addr,
    output logic                    rd_bit,
    input  logic                    wr_en,
    input  logic [HISTORY_BITS-1:0] wr_addr,
    input  logic                    wr_bit
);

    logic [ENTRIES-1:0] bits_reg;
    logic [ENTRIES-1:0] bits_next;

    always_comb
    begin
        bits_next = bits_reg;
        if (wr_en)
        begin
            bits_next[wr_addr] = wr_bit;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_reg <= '0;
        end
        else
        begin
            bits_reg <= bits_next;
        end
    end

    assign rd_bit = bits_reg[rd_addr];

endmodule

@@ rtl/tlp_counters.sv @@
`timescale 1ns / 1ps

// Saturating statistics counters, one bumped per retired branch.
module tlp_counters (
    input  logic                            clk,
    input  logic                            rst_n,
    input  tlp_pkg::count_bump_t            bump,
    output logic [tlp_pkg::COUNT_BITS-1:0]  correct_count,
    output logic [tlp_pkg::COUNT_BITS-1:0]  wrong_count,
    output logic [tlp_pkg::COUNT_BITS-1:0]  miss_count
);

    logic [tlp_pkg::COUNT_BITS-1:0] correct_reg;
    logic [tlp_pkg::COUNT_BITS-1:0] correct_next;
    logic [tlp_pkg::COUNT_BITS-1:0] wrong_reg;
    logic [tlp_pkg::COUNT_BITS-1:0] wrong_next;
    logic [tlp_pkg::COUNT_BITS-1:0] miss_reg;
    logic [tlp_pkg::COUNT_BITS-1:0] miss_next;

    // Increment the selected counter, holding at all ones
    always_comb
    begin
        correct_next = correct_reg;
        wrong_next   = wrong_reg;
        miss_next    = miss_reg;
        if (bump.en)
        begin
            case (bump.code)
                tlp_pkg::OUTCOME_CORRECT:
                begin
                    if (correct_reg != '1)
                    begin
                        correct_next = correct_reg + tlp_pkg::COUNT_BITS'(1);
                    end
                end
                tlp_pkg::OUTCOME_WRONG:
                begin
                    if (wrong_reg != '1)
                    begin
                        wrong_next = wrong_reg + tlp_pkg::COUNT_BITS'(1);
                    end
                end
                tlp_pkg::OUTCOME_MISS:
                begin
                    if (miss_reg != '1)
                    begin
                        miss_next = miss_reg + tlp_pkg::COUNT_BITS'(1);
                    end
                end
                default:
                begin
                    correct_next = correct_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            correct_reg <= '0;
            wrong_reg   <= '0;
            miss_reg    <= '0;
        end
        else
        begin
            correct_reg <= correct_next;
            wrong_reg   <= wrong_next;
            miss_reg    <= miss_next;
        end
    end

    assign correct_count = correct_reg;
    assign wrong_count   = wrong_reg;
    assign miss_count    = miss_reg;

endmodule

@@ rtl/two_level_local_history_predictor_top.sv @@
`timescale 1ns / 1ps

// Two-level local-history branch predictor. One branch request is taken per clock
// unless the update stage is blocked by output back-pressure or the sweep runs.
// The slot memory read is registered on acceptance; the update stage then
// classifies, writes back history/tag and the pattern bit, and loads the output
// register once it is empty or its result is taken. Back-to-back branches to the
// same slot are handled by forwarding the update-stage write data into the next
// read. After reset the slot memory is swept to zero; no request is accepted
// during the sweep. TABLE_ENTRIES must be a power of two.
// The counts reported with a result are totals including that branch.
module two_level_local_history_predictor_top #(
    parameter int TABLE_ENTRIES = tlp_pkg::TABLE_ENTRIES_DEFAULT,
    parameter int HISTORY_BITS  = tlp_pkg::HISTORY_BITS_DEFAULT,
    parameter int ADDRESS_BITS  = tlp_pkg::ADDRESS_BITS_DEFAULT
) (
    input  logic         clk,
    input  logic         rst_n,
    tlp_branch_if.sink   branch,
    tlp_result_if.source result
);

    localparam int AW = $clog2(TABLE_ENTRIES);
    localparam int TB = (ADDRESS_BITS < tlp_pkg::FIELD_BITS) ? ADDRESS_BITS
                                                             : tlp_pkg::FIELD_BITS;
    localparam int HB = HISTORY_BITS;
    localparam int DW = HB + 2 * TB;

    logic          accept;
    logic          advance;
    logic          clear_busy;
    logic [AW-1:0] in_slot;

    // Update stage registers
    logic          s1_valid_reg;
    logic          s1_valid_next;
    logic [TB-1:0] s1_baddr_reg;
    logic [TB-1:0] s1_taddr_reg;
    logic          s1_taken_reg;
    logic [AW-1:0] s1_slot_reg;
    logic          fwd_sel_reg;
    logic [DW-1:0] fwd_data_reg;

    // Update stage logic
    logic [DW-1:0] rd_data;
    logic [DW-1:0] entry;
    logic [HB-1:0] hist;
    logic [TB-1:0] tag_b;
    logic [TB-1:0] tag_t;
    logic          pred;
    logic          tag_hit;
    logic [HB-1:0] new_hist;
    logic [DW-1:0] wr_data;
    tlp_pkg::outcome_t    code;
    tlp_pkg::count_bump_t bump;

    // Output register
    logic              out_valid_reg;
    logic              out_valid_next;
    tlp_pkg::outcome_t out_code_reg;
    logic              out_pred_reg;

    // Handshake
    assign advance      = s1_valid_reg && (!out_valid_reg || result.ready);
    assign branch.ready = !clear_busy && (!s1_valid_reg || advance);
    assign accept       = branch.valid && branch.ready;
    assign in_slot      = branch.branch_address[AW-1:0];

    tlp_slot_mem #(
        .DEPTH (TABLE_ENTRIES),
        .DW    (DW),
        .AW    (AW)
    ) u_slot_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rd_addr (in_slot),
        .rd_data (rd_data),
        .wr_en   (advance),
        .wr_addr (s1_slot_reg),
        .wr_data (wr_data),
        .busy    (clear_busy)
    );

    // Stage valid
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (advance)
        begin
            s1_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            fwd_sel_reg  <= 1'b0;
        end
        else
        begin
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                fwd_sel_reg <= advance && (s1_slot_reg == in_slot);
            end
        end
    end

    // Request capture and forwarded write data
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_baddr_reg <= branch.branch_address[TB-1:0];
            s1_taddr_reg <= branch.target_address[TB-1:0];
            s1_taken_reg <= branch.taken;
            s1_slot_reg  <= in_slot;
            fwd_data_reg <= wr_data;
        end
    end

    // Entry decode with bypass of the write that raced the read
    assign entry   = fwd_sel_reg ? fwd_data_reg : rd_data;
    assign hist    = entry[HB-1:0];
    assign tag_b   = entry[HB +: TB];
    assign tag_t   = entry[HB + TB +: TB];
    assign tag_hit = (tag_b == s1_baddr_reg) && (tag_t == s1_taddr_reg);

    tlp_pattern_table #(
        .HISTORY_BITS (HB)
    ) u_pattern_table (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_addr (hist),
        .rd_bit  (pred),
        .wr_en   (advance),
        .wr_addr (hist),
        .wr_bit  (s1_taken_reg)
    );

    // Classify and build the write-back entry
    always_comb
    begin
        if (!tag_hit)
        begin
            code = tlp_pkg::OUTCOME_MISS;
        end
        else if (s1_taken_reg == pred)
        begin
            code = tlp_pkg::OUTCOME_CORRECT;
        end
        else
        begin
            code = tlp_pkg::OUTCOME_WRONG;
        end
    end

    assign new_hist = (hist << 1) | HB'(s1_taken_reg);
    assign wr_data  = {s1_taddr_reg, s1_baddr_reg, new_hist};
    assign bump.en   = advance;
    assign bump.code = code;

    tlp_counters u_counters (
        .clk           (clk),
        .rst_n         (rst_n),
        .bump          (bump),
        .correct_count (result.correct_count),
        .wrong_count   (result.wrong_count),
        .miss_count    (result.miss_count)
    );

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (advance)
        begin
            out_valid_next = 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_code_reg <= code;
            out_pred_reg <= pred;
        end
    end

    assign result.valid           = out_valid_reg;
    assign result.outcome         = out_code_reg;
    assign result.predicted_taken = out_pred_reg;

    // No request enters or is in flight while the slot memory is swept
    a_no_work_during_clear: assert property (@(posedge clk) disable iff (!rst_n)
        clear_busy |-> (!branch.ready && !s1_valid_reg))
        else $error("request in flight during slot memory clear");

    // Bypass selected for a request newly in the update stage needs a write-back alongside its acceptance
    a_fwd_needs_stage: assert property (@(posedge clk) disable iff (!rst_n)
        fwd_sel_reg && !clear_busy && $rose(s1_valid_reg) |-> $past(advance))
        else $error("bypass selected without a preceding write");

    // Totals change only on a retiring branch, and by at most one counter
    a_count_update: assert property (@(posedge clk) disable iff (!rst_n)
        ##1 ($countones({result.correct_count != $past(result.correct_count),
                         result.wrong_count != $past(result.wrong_count),
                         result.miss_count != $past(result.miss_count)})
             <= ($past(advance) ? 1 : 0)))
        else $error("statistics counters changed unexpectedly");

endmodule

@@ verif/two_level_local_history_predictor_top_test.sv @@
`timescale 1ns / 1ps

module two_level_local_history_predictor_top_test;

    localparam int SLOTS         = tlp_pkg::TABLE_ENTRIES_DEFAULT;
    localparam int SLOT_BITS     = $clog2(tlp_pkg::TABLE_ENTRIES_DEFAULT);
    localparam int HIST_BITS     = tlp_pkg::HISTORY_BITS_DEFAULT;
    localparam int PATTERNS      = 1 << tlp_pkg::HISTORY_BITS_DEFAULT;
    localparam int POOL_SIZE     = 20;
    localparam int SETTLE_CYCLES = 10;
    // reset sweep of the slot memory plus generous room for long stalls
    localparam int STALL_LIMIT   = 4 * tlp_pkg::TABLE_ENTRIES_DEFAULT + 2000;

    localparam logic [tlp_pkg::FIELD_BITS-1:0] ALL_ONES = '1;

    typedef struct packed {
        tlp_pkg::outcome_t              code;
        logic                           predicted;
        logic [tlp_pkg::COUNT_BITS-1:0] correct;
        logic [tlp_pkg::COUNT_BITS-1:0] wrong;
        logic [tlp_pkg::COUNT_BITS-1:0] miss;
    } branch_verdict_t;

    // Local-history predictor mirror and queue of expected results
    class branch_scoreboard;
        bit [HIST_BITS-1:0]           local_history [SLOTS];
        bit                           pattern_bits  [PATTERNS];
        bit [tlp_pkg::FIELD_BITS-1:0] tag_branch    [SLOTS];
        bit [tlp_pkg::FIELD_BITS-1:0] tag_target    [SLOTS];
        bit [tlp_pkg::COUNT_BITS-1:0] correct_total;
        bit [tlp_pkg::COUNT_BITS-1:0] wrong_total;
        bit [tlp_pkg::COUNT_BITS-1:0] miss_total;
        branch_verdict_t              verdicts [$];
        int                           mismatches;

        function new();
            foreach (local_history[i]) local_history[i] = '0;
            foreach (pattern_bits[i]) pattern_bits[i] = 1'b0;
            foreach (tag_branch[i]) tag_branch[i] = '0;
            foreach (tag_target[i]) tag_target[i] = '0;
            correct_total = '0;
            wrong_total   = '0;
            miss_total    = '0;
            mismatches    = 0;
        endfunction

        // counters stick at all ones
        function bit [tlp_pkg::COUNT_BITS-1:0] bump(bit [tlp_pkg::COUNT_BITS-1:0] count);
            return (count == '1) ? count : count + 1'b1;
        endfunction

        function int pending();
            return verdicts.size();
        endfunction

        function void note_branch(bit [tlp_pkg::FIELD_BITS-1:0] baddr,
                                  bit [tlp_pkg::FIELD_BITS-1:0] taddr, bit tk);
            branch_verdict_t    v;
            bit [SLOT_BITS-1:0] slot;
            bit [HIST_BITS-1:0] hist;
            slot        = baddr[SLOT_BITS-1:0];
            hist        = local_history[slot];
            v.predicted = pattern_bits[hist];
            // tag pair decides whether the prediction counts at all
            if (baddr != tag_branch[slot] || taddr != tag_target[slot])
            begin
                v.code     = tlp_pkg::OUTCOME_MISS;
                miss_total = bump(miss_total);
            end
            else if (tk == v.predicted)
            begin
                v.code        = tlp_pkg::OUTCOME_CORRECT;
                correct_total = bump(correct_total);
            end
            else
            begin
                v.code      = tlp_pkg::OUTCOME_WRONG;
                wrong_total = bump(wrong_total);
            end
            // tables are updated on every branch, miss or not
            pattern_bits[hist]  = tk;
            local_history[slot] = {hist[HIST_BITS-2:0], tk};
            tag_branch[slot]    = baddr;
            tag_target[slot]    = taddr;
            v.correct = correct_total;
            v.wrong   = wrong_total;
            v.miss    = miss_total;
            verdicts.insert(verdicts.size(), v);
        endfunction

        function void check_result(logic [1:0] code, logic predicted,
                                   logic [tlp_pkg::COUNT_BITS-1:0] correct,
                                   logic [tlp_pkg::COUNT_BITS-1:0] wrong,
                                   logic [tlp_pkg::COUNT_BITS-1:0] miss);
            branch_verdict_t v;
            if (verdicts.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%t: result with nothing pending: outcome %0d", $realtime, code);
                return;
            end
            v = verdicts.pop_front();
            if (code !== v.code || predicted !== v.predicted || correct !== v.correct ||
                wrong !== v.wrong || miss !== v.miss)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("%t: result mismatch", $realtime);
                    $display("  expected outcome %0d pred %0d correct %0d wrong %0d miss %0d",
                             v.code, v.predicted, v.correct, v.wrong, v.miss);
                    $display("  actual   outcome %0d pred %0d correct %0d wrong %0d miss %0d",
                             code, predicted, correct, wrong, miss);
                end
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;

    tlp_branch_if branch_ch ();
    tlp_result_if result_ch ();

    two_level_local_history_predictor_top i_dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .branch (branch_ch),
        .result (result_ch)
    );

    branch_scoreboard  sb;
    int                sender_idle_pct;
    int                receiver_idle_pct;
    int                idle_cycles = 0;

    // branch pool: well-formed recurring branches with periodic outcomes
    logic [tlp_pkg::FIELD_BITS-1:0] pool_branch [POOL_SIZE];
    logic [tlp_pkg::FIELD_BITS-1:0] pool_target [POOL_SIZE];
    logic [7:0]                     pool_pattern [POOL_SIZE];
    int                             pool_period [POOL_SIZE];
    int                             pool_step [POOL_SIZE];

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Result sink: random back-pressure
    always @(posedge clk)
    begin
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
            result_ch.ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    // Request/result monitor and stall watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (branch_ch.valid && branch_ch.ready)
                sb.note_branch(branch_ch.branch_address, branch_ch.target_address,
                               branch_ch.taken);
            if (result_ch.valid && result_ch.ready)
                sb.check_result(result_ch.outcome, result_ch.predicted_taken,
                                result_ch.correct_count, result_ch.wrong_count,
                                result_ch.miss_count);
            if ((branch_ch.valid && branch_ch.ready) || (result_ch.valid && result_ch.ready))
                idle_cycles <= 0;
            else if (idle_cycles >= STALL_LIMIT)
            begin
                $display("watchdog: no handshake for %0d cycles", STALL_LIMIT);
                $display("two_level_local_history_predictor_top regression: fail");
                $finish;
            end
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic logic [tlp_pkg::FIELD_BITS-1:0] rand_addr();
        logic [63:0] wide;
        wide = {$urandom, $urandom};
        return wide[tlp_pkg::FIELD_BITS-1:0];
    endfunction

    // Present one branch request and hold it until accepted
    task automatic send_branch(input logic [tlp_pkg::FIELD_BITS-1:0] baddr,
                               input logic [tlp_pkg::FIELD_BITS-1:0] taddr,
                               input logic tk);
        while ($urandom_range(99) < sender_idle_pct)
        begin
            branch_ch.valid <= 1'b0;
            @(posedge clk);
        end
        branch_ch.valid          <= 1'b1;
        branch_ch.branch_address <= baddr;
        branch_ch.target_address <= taddr;
        branch_ch.taken          <= tk;
        @(posedge clk);
        while (!branch_ch.ready)
            @(posedge clk);
    endtask

    // Hold off the sender until every pending result has drained
    task automatic drain_results();
        branch_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (sb.pending() != 0);
    endtask

    task automatic build_pool();
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            pool_branch[i]  = rand_addr();
            pool_target[i]  = rand_addr();
            // some entries alias onto the slot of an earlier one
            if (i > 0 && $urandom_range(3) == 0)
                pool_branch[i][SLOT_BITS-1:0] = pool_branch[$urandom_range(i - 1)][SLOT_BITS-1:0];
            pool_pattern[i] = 8'($urandom);
            pool_period[i]  = $urandom_range(1, 6);
            pool_step[i]    = 0;
        end
    endtask

    task automatic run_random(input int count);
        int               pick;
        int               roll;
        logic             tk;
        build_pool();
        pick = 0;
        for (int n = 0; n < count; n++)
        begin
            roll = $urandom_range(99);
            if (roll < 80)
            begin
                // recurring branch; repeats often to hit same-slot forwarding
                if ($urandom_range(99) >= 30)
                    pick = $urandom_range(POOL_SIZE - 1);
                tk = pool_pattern[pick][pool_step[pick] % pool_period[pick]];
                if ($urandom_range(9) == 0)
                    tk = ~tk;
                pool_step[pick]++;
                send_branch(pool_branch[pick], pool_target[pick], tk);
            end
            else if (roll < 90)
            begin
                // known branch with a stray target
                send_branch(pool_branch[$urandom_range(POOL_SIZE - 1)], rand_addr(),
                            1'($urandom_range(1)));
            end
            else
                send_branch(rand_addr(), rand_addr(), 1'($urandom_range(1)));
        end
    endtask

    initial
    begin
        sb                       = new();
        rst_n                    = 1'b0;
        branch_ch.valid          = 1'b0;
        branch_ch.branch_address = '0;
        branch_ch.target_address = '0;
        branch_ch.taken          = 1'b0;
        sender_idle_pct          = 9;
        receiver_idle_pct        = 69;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        // zero branch/target matches the cleared tags right after reset
        send_branch('0, '0, 1'b1);
        send_branch('0, '0, 1'b0);
        send_branch('0, '0, 1'b0);
        // all-ones fields: first a miss, then hits
        send_branch(ALL_ONES, ALL_ONES, 1'b1);
        send_branch(ALL_ONES, ALL_ONES, 1'b1);
        send_branch(ALL_ONES, ALL_ONES, 1'b0);
        // target mismatch on slot zero
        send_branch('0, ALL_ONES, 1'b1);
        // aliasing onto slot zero from a higher address
        send_branch(48'h400, '0, 1'b1);
        send_branch(48'h400, '0, 1'b1);
        send_branch({ALL_ONES[tlp_pkg::FIELD_BITS-1:SLOT_BITS], {SLOT_BITS{1'b0}}}, 48'h5,
                    1'b0);
        // short loop: taken three times, then falls through
        for (int i = 0; i < 12; i++)
            send_branch(48'h1234, 48'h5678, (i % 4) != 3);

        run_random(650);
        drain_results();

        sender_idle_pct   = 69;
        receiver_idle_pct = 9;
        run_random(650);
        drain_results();

        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random(630);

        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (sb.mismatches == 0)
            $display("two_level_local_history_predictor_top regression: pass");
        else
            $display("two_level_local_history_predictor_top regression: fail");
        $finish;
    end

endmodule

@@ sim.f @@
rtl/tlp_pkg.sv
rtl/tlp_branch_if.sv
rtl/tlp_result_if.sv
rtl/tlp_slot_mem.sv
rtl/tlp_pattern_table.sv
rtl/tlp_counters.sv
rtl/two_level_local_history_predictor_top.sv
verif/two_level_local_history_predictor_top_test.sv
